### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the transmitter.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hw/rtl/utx_pkg.sv
// Shared types and constants of the UART multibyte transmitter.
// No dependencies; imported by the controller, datapath and top level.
package utx_pkg;

    localparam int BYTE_W = 8;

    // Item kinds carried on s_tuser.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_BUSY
    } utx_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store_wr;
        logic start;
        logic shift_out;
        logic stop_out;
        logic next_byte;
        logic finish;
    } utx_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic store_full;
        logic phase_data;
        logic phase_stop;
        logic bytes_one;
    } utx_status_t;

    // Result flags produced by the controller.
    typedef struct packed {
        logic overflow;
        logic rejected;
        logic done;
        logic busy;
    } utx_flags_t;

    // Result item layout, lowest bit last.
    typedef struct packed {
        logic [2:0] pad;
        logic       overflow;
        logic       load_rejected;
        logic       done_res;
        logic       busy_res;
        logic       tx_line;
    } utx_result_t;

endpackage

### hw/rtl/utx_ctrl.sv
// Controller state machine of the UART multibyte transmitter.
// Depends on utx_pkg; drives datapath commands and the result flags.
module utx_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                item_acc,
    input  logic                item_op,
    input  logic                item_last,
    input  utx_pkg::utx_status_t status,
    output utx_pkg::utx_cmd_t   cmd,
    output utx_pkg::utx_flags_t flags
);
    import utx_pkg::*;

    utx_state_t state_reg, state_next;
    logic       send_en_reg;
    logic       load_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            send_en_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                send_en_reg <= cfg_wr_data;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (cmd.finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        flags   = '0;
        load_ok = (state_reg == ST_IDLE) && send_en_reg;
        if (item_acc) begin
            if (item_op == OP_LOAD) begin
                if (load_ok) begin
                    cmd.store_wr   = !status.store_full;
                    flags.overflow = status.store_full;
                    // A full store still holds bytes, so a last mark always starts.
                    cmd.start      = item_last;
                end else begin
                    flags.rejected = 1'b1;
                end
            end else if (state_reg == ST_BUSY) begin
                priority if (status.phase_data) begin
                    cmd.shift_out = 1'b1;
                end else if (status.phase_stop) begin
                    cmd.stop_out = 1'b1;
                end else if (status.bytes_one) begin
                    cmd.finish = 1'b1;
                    flags.done = 1'b1;
                end else begin
                    cmd.next_byte = 1'b1;
                end
            end
        end
        // Busy after this item: a start leaves idle, a finish ends sending.
        flags.busy = (state_reg == ST_BUSY) ? !cmd.finish : cmd.start;
    end

endmodule

### hw/rtl/utx_datapath.sv
// Datapath of the UART multibyte transmitter: byte store, counters, line level.
// Depends on utx_pkg; driven by commands from utx_ctrl.
module utx_datapath #(
    parameter int STORE_DEPTH = 8,
    parameter int DATA_BITS   = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  utx_pkg::utx_cmd_t         cmd,
    input  logic [utx_pkg::BYTE_W-1:0] data_byte,
    output utx_pkg::utx_status_t      status,
    output logic                      line_next
);
    import utx_pkg::*;

    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int BIT_W = $clog2(DATA_BITS + 3);

    logic [BYTE_W-1:0] store_mem [STORE_DEPTH];

    logic              line_reg;
    logic [BYTE_W-1:0] tx_byte_reg;
    logic [BIT_W-1:0]  bit_count_reg, bit_count_next;
    logic [CNT_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [CNT_W-1:0]  fill_count_reg, fill_count_next;

    logic [BIT_W-1:0]  bit_inc;
    logic [CNT_W-1:0]  bytes_dec;
    logic [CNT_W-1:0]  bytes_dec2;
    logic [CNT_W-1:0]  fill_inc;
    logic [CNT_W-1:0]  fill_dec;
    logic [IDX_W-1:0]  wr_idx;
    logic [IDX_W-1:0]  first_idx;
    logic [IDX_W-1:0]  next_idx;
    logic              bytes_zero;

    assign bit_inc    = bit_count_reg + BIT_W'(1);
    assign bytes_dec  = bytes_left_reg - CNT_W'(1);
    assign bytes_dec2 = bytes_left_reg - CNT_W'(2);
    assign fill_inc   = fill_count_reg + CNT_W'(1);
    assign fill_dec   = fill_count_reg - CNT_W'(1);
    assign wr_idx     = fill_count_reg[IDX_W-1:0];
    assign first_idx  = fill_dec[IDX_W-1:0];
    assign next_idx   = bytes_dec2[IDX_W-1:0];
    assign bytes_zero = (bytes_left_reg == '0);

    assign status.store_full = (fill_count_reg == CNT_W'(STORE_DEPTH));
    assign status.phase_data = (bit_inc <= BIT_W'(DATA_BITS));
    assign status.phase_stop = (bit_inc == BIT_W'(DATA_BITS + 1));
    assign status.bytes_one  = (bytes_left_reg == CNT_W'(1));

    // The store is written only while idle. The byte of the frame being sent is
    // copied out when its start bit goes out and shifts right as its bits go out;
    // on the starting load the new byte is taken straight from the input.
    always_ff @(posedge aclk) begin
        if (cmd.store_wr) begin
            store_mem[wr_idx] <= data_byte;
        end
        if (cmd.start) begin
            tx_byte_reg <= cmd.store_wr ? data_byte : store_mem[first_idx];
        end else if (cmd.next_byte) begin
            tx_byte_reg <= store_mem[next_idx];
        end else if (cmd.shift_out) begin
            tx_byte_reg <= tx_byte_reg >> 1;
        end
    end

    always_comb begin
        line_next       = line_reg;
        bit_count_next  = bit_count_reg;
        bytes_left_next = bytes_left_reg;
        fill_count_next = fill_count_reg;
        if (cmd.store_wr) begin
            fill_count_next = fill_inc;
        end
        priority if (cmd.start) begin
            bytes_left_next = cmd.store_wr ? fill_inc : fill_count_reg;
            fill_count_next = '0;
            bit_count_next  = '0;
            line_next       = 1'b0;
        end else if (cmd.shift_out) begin
            bit_count_next = bit_inc;
            line_next      = bytes_zero ? 1'b0 : tx_byte_reg[0];
        end else if (cmd.stop_out) begin
            bit_count_next = bit_inc;
            line_next      = 1'b1;
        end else if (cmd.next_byte) begin
            bit_count_next  = '0;
            bytes_left_next = bytes_dec;
            line_next       = 1'b0;
        end else if (cmd.finish) begin
            bit_count_next  = '0;
            bytes_left_next = bytes_dec;
        end else begin
            line_next = line_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg       <= 1'b1;
            bit_count_reg  <= '0;
            bytes_left_reg <= '0;
            fill_count_reg <= '0;
        end else begin
            line_reg       <= line_next;
            bit_count_reg  <= bit_count_next;
            bytes_left_reg <= bytes_left_next;
            fill_count_reg <= fill_count_next;
        end
    end

endmodule

### hw/rtl/uart_multibyte_bit_transmitter.sv
// Top level of the tick-driven UART 8N1 multibyte transmitter.
// Latency: the result item of an accepted item appears in the next cycle.
// Throughput: one item per clock while results are taken; the single output
// register is refilled in the same cycle its result is taken. Reset (aresetn low,
// synchronous): line high, idle, store empty, send_enable set; store contents
// stay undefined until loaded. Depends on utx_pkg, utx_ctrl and utx_datapath.
module uart_multibyte_bit_transmitter #(
    parameter int STORE_DEPTH = 8,
    parameter int DATA_BITS   = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration: the send_enable register.
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    // Input items.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] op: 0 tick, 1 load
    input  logic       s_tlast,   // last_byte
    // Result items.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] tx_line, [1] busy_res, [2] done_res,
                                  // [3] load_rejected, [4] overflow, [7:5] zero
);
    import utx_pkg::*;

    // Every item, tick or load, is decided in the cycle it is accepted; the
    // controller and datapath update their state at that edge and the result
    // item is captured in m_tdata_reg alongside.

    logic        item_acc;
    utx_cmd_t    cmd;
    utx_status_t status;
    utx_flags_t  flags;
    logic        line_next;
    utx_result_t result;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  m_tdata_reg;

    // A new item is taken whenever the output register is free or being emptied.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign item_acc = s_tvalid && s_tready;

    utx_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_acc    (item_acc),
        .item_op     (s_tuser),
        .item_last   (s_tlast),
        .status      (status),
        .cmd         (cmd),
        .flags       (flags)
    );

    utx_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .DATA_BITS   (DATA_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .data_byte (s_tdata),
        .status    (status),
        .line_next (line_next)
    );

    always_comb begin
        result.pad           = '0;
        result.overflow      = flags.overflow;
        result.load_rejected = flags.rejected;
        result.done_res      = flags.done;
        result.busy_res      = flags.busy;
        result.tx_line       = line_next;
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (item_acc) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload register: loaded only with an accepted item's result.
    always_ff @(posedge aclk) begin
        if (item_acc) begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### hw/rtl/utx_checker.sv
// Port-level checks for the UART multibyte transmitter, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module utx_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A pending result that is not taken holds its value.
    `ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // With no result pending, the block must take input.
    `ASSERT_IMP(a_ready, aclk, aresetn, !m_tvalid, s_tready)

    // Every accepted item offers its result in the next cycle.
    `ASSERT_NXT(a_result_follows, aclk, aresetn, s_tvalid && s_tready, m_tvalid)

    // The item that ends a message reports idle.
    `ASSERT_IMP(a_done_idle, aclk, aresetn, m_tvalid && m_tdata[2], !m_tdata[1])

    // An idle line is high.
    `ASSERT_IMP(a_idle_high, aclk, aresetn, m_tvalid && !m_tdata[1], m_tdata[0])

endmodule

bind uart_multibyte_bit_transmitter utx_checker u_utx_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### test/tb.sv
// Self-checking testbench for the tick-driven UART 8N1 multibyte transmitter.
// Drives load and tick items, predicts every result item and compares it.
// Depends on utx_pkg and uart_multibyte_bit_transmitter.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utx_pkg::*;

    localparam int STORE_DEPTH  = 8;
    localparam int DATA_BITS    = 8;
    localparam int IDX_W        = $clog2(STORE_DEPTH);
    localparam int RANDOM_ITEMS = 1620;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;

    // Stall patterns of the result side.
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_MOSTLY,
        RX_SPARSE
    } rx_mode_t;

    // All inputs of the block start at known values.
    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata     = 8'h00;
    logic       s_tuser     = OP_TICK;
    logic       s_tlast     = 1'b0;
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;

    uart_multibyte_bit_transmitter #(
        .STORE_DEPTH(STORE_DEPTH),
        .DATA_BITS  (DATA_BITS)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The transmitter as the testbench sees it. These variables mirror the
    // send_enable register, the line, the bit and byte counters, the idle
    // flag, the fill level and the byte store.
    logic       tx_enable   = 1'b1;
    logic       tx_line_lvl = 1'b1;
    logic [3:0] tx_bitcnt   = '0;
    logic [3:0] tx_left     = '0;
    logic       tx_idle     = 1'b1;
    logic [3:0] tx_fill     = '0;
    logic [7:0] tx_store [STORE_DEPTH];

    // Result items predicted for accepted input items, oldest first.
    utx_result_t line_results_q [$];

    int items_accepted = 0;
    int mismatches     = 0;
    int cycle_count    = 0;
    int burst_left     = 0;

    // Long hold-off requests for the result side; the receiver counts them.
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    rx_mode_t rx_mode = RX_ALWAYS;
    int       rx_left = 0;

    // Advances the mirrored transmitter by one item and returns the result
    // item that the block should produce for it.
    function automatic utx_result_t step_transmitter(logic op, logic [7:0] data,
                                                     logic last);
        utx_result_t res;
        logic [3:0]  idx;
        res = '0;
        if (op == OP_LOAD) begin
            if (!tx_idle || !tx_enable) begin
                // Loads are refused while sending or while disabled; the last
                // mark is dropped with the byte.
                res.load_rejected = 1'b1;
            end else begin
                if (tx_fill < STORE_DEPTH) begin
                    tx_store[tx_fill[IDX_W-1:0]] = data;
                    tx_fill = tx_fill + 4'd1;
                end else begin
                    // The store is full: the byte is lost, but a last mark
                    // still sends what was stored.
                    res.overflow = 1'b1;
                end
                if (last && tx_fill != 0) begin
                    tx_left     = tx_fill;
                    tx_fill     = '0;
                    tx_bitcnt   = '0;
                    tx_idle     = 1'b0;
                    tx_line_lvl = 1'b0;
                end
            end
        end else if (!tx_idle) begin
            tx_bitcnt = tx_bitcnt + 4'd1;
            if (tx_bitcnt <= DATA_BITS) begin
                // Data bits go out LSB first, from the last stored byte down.
                idx = tx_left - 4'd1;
                if (tx_left != 0 && idx < STORE_DEPTH) begin
                    tx_line_lvl              = tx_store[idx[IDX_W-1:0]][0];
                    tx_store[idx[IDX_W-1:0]] = tx_store[idx[IDX_W-1:0]] >> 1;
                end else begin
                    tx_line_lvl = 1'b0;
                end
            end else if (tx_bitcnt == DATA_BITS + 1) begin
                tx_line_lvl = 1'b1;
            end else begin
                tx_bitcnt = '0;
                tx_left   = tx_left - 4'd1;
                if (tx_left == 0) begin
                    tx_idle      = 1'b1;
                    res.done_res = 1'b1;
                end else begin
                    tx_line_lvl = 1'b0;
                end
            end
        end
        // A tick while idle changes nothing and the line stays high.
        res.tx_line  = tx_line_lvl;
        res.busy_res = !tx_idle;
        return res;
    endfunction

    // Offers one item and waits until the block takes it. The valid stays high
    // afterwards so that the next item can follow in the very next cycle;
    // every task that lets time pass without an item lowers it first.
    task automatic send_item(logic op, logic [7:0] data, logic last);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        line_results_q.push_back(step_transmitter(op, data, last));
        items_accepted++;
    endtask

    task automatic idle_sender(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Sends in bursts of random length with random gaps in between.
    task automatic send_paced(logic op, logic [7:0] data, logic last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
        end
        burst_left--;
        send_item(op, data, last);
    endtask

    // Ticks carry random data and last bits, which the block must ignore.
    task automatic send_tick();
        send_paced(OP_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (line_results_q.size() != 0) @(posedge aclk);
    endtask

    // The register is only written with no item in flight. After the write the task
    // waits so that the next driver starts on a fresh edge.
    task automatic write_send_enable(logic value);
        wait_all_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tx_enable = value;
        @(posedge aclk);
    endtask

    // Ticks until the running message has gone out; now and then a load is
    // thrown in, which the block must refuse while it is sending.
    task automatic finish_message(int noise_odds);
        while (!tx_idle) begin
            if ($urandom_range(1, noise_odds) == 1)
                send_paced(OP_LOAD, 8'($urandom), 1'($urandom_range(0, 1)));
            else
                send_tick();
        end
    endtask

    task automatic test_idle_ticks();
        send_paced(OP_TICK, 8'hFF, 1'b1);
        send_paced(OP_TICK, 8'h00, 1'b0);
    endtask

    // One all-ones byte, with a refused load in the middle of its frame and
    // an idle tick after it.
    task automatic test_single_frame();
        int i;
        send_paced(OP_LOAD, 8'hFF, 1'b1);
        for (i = 0; i < 4; i++) send_tick();
        send_paced(OP_LOAD, 8'h00, 1'b0);
        finish_message(1000000);
        send_tick();
    endtask

    // Disabled loads are refused; a disable during sending lets the message
    // run to its end.
    task automatic test_send_disable();
        int i;
        write_send_enable(1'b0);
        send_paced(OP_LOAD, 8'hFF, 1'b1);
        send_tick();
        write_send_enable(1'b1);
        send_paced(OP_LOAD, 8'h00, 1'b0);
        send_paced(OP_LOAD, 8'h81, 1'b1);
        for (i = 0; i < 3; i++) send_tick();
        write_send_enable(1'b0);
        send_paced(OP_LOAD, 8'h7E, 1'b1);
        finish_message(1000000);
        send_paced(OP_LOAD, 8'h55, 1'b1);
        write_send_enable(1'b1);
    endtask

    // Nine loads into an eight-byte store: the ninth carries the last mark,
    // is dropped and still starts the message.
    task automatic test_store_full();
        int i;
        for (i = 0; i < STORE_DEPTH; i++) send_paced(OP_LOAD, 8'($urandom), 1'b0);
        send_paced(OP_LOAD, 8'($urandom), 1'b1);
        finish_message(20);
    endtask

    // The result side holds off for a long stretch while items keep coming
    // back to back, so the block fills up and must stall its input. Then the
    // sender pauses until every result has arrived.
    task automatic test_output_holdoff();
        int i;
        wait_all_results();
        hold_reqs++;
        for (i = 0; i < 6; i++) send_item(OP_LOAD, 8'($urandom), i == 5);
        for (i = 0; i < 40; i++) send_item(OP_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
        wait_all_results();
        finish_message(30);
        wait_all_results();
    endtask

    // Mostly well-formed messages of random bytes, mixed with stray ticks,
    // loads left without a last mark, refused loads and register changes.
    task automatic test_random_messages();
        int stop_at;
        int len;
        int pick;
        int i;
        int cut;
        stop_at = items_accepted + RANDOM_ITEMS;
        while (items_accepted < stop_at) begin
            case ($urandom_range(0, 19))
                0: write_send_enable($urandom_range(0, 3) != 0);
                1: begin
                    repeat ($urandom_range(1, 4)) send_tick();
                end
                2: begin
                    repeat ($urandom_range(1, 3)) send_paced(OP_LOAD, 8'($urandom), 1'b0);
                end
                default: begin
                    // Mostly short messages; a few run past the store depth.
                    pick = $urandom_range(0, 9);
                    if (pick < 6)      len = $urandom_range(1, 3);
                    else if (pick < 9) len = $urandom_range(4, 8);
                    else               len = $urandom_range(9, 11);
                    for (i = 0; i < len; i++)
                        send_paced(OP_LOAD, 8'($urandom), i == len - 1);
                    if (!tx_idle && $urandom_range(0, 7) == 0) begin
                        // Change the register while the message is going out.
                        cut = $urandom_range(1, 12);
                        for (i = 0; i < cut && !tx_idle; i++) send_tick();
                        write_send_enable(1'($urandom_range(0, 1)));
                    end
                    finish_message(16);
                end
            endcase
        end
    endtask

    // Receiver: a random stall pattern, drawn anew whenever its random run ends,
    // overridden by a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(5, 60);
            end
            rx_left--;
            case (rx_mode)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                default:   m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Checker: every result item taken from the block is compared, field by
    // field, with the oldest prediction.
    always @(posedge aclk) begin
        utx_result_t want;
        utx_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = utx_result_t'(m_tdata);
            if (line_results_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result item %h with nothing predicted", m_tdata);
            end else begin
                want = line_results_q.pop_front();
                if (got.tx_line !== want.tx_line || got.busy_res !== want.busy_res ||
                    got.done_res !== want.done_res ||
                    got.load_rejected !== want.load_rejected ||
                    got.overflow !== want.overflow || got.pad !== want.pad) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"mismatch: expected line=%b busy=%b done=%b rej=%b ovf=%b",
                                  " pad=%b, got line=%b busy=%b done=%b rej=%b ovf=%b pad=%b"},
                                 want.tx_line, want.busy_res, want.done_res,
                                 want.load_rejected, want.overflow, want.pad,
                                 got.tx_line, got.busy_res, got.done_res,
                                 got.load_rejected, got.overflow, got.pad);
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** uart_multibyte_bit_transmitter: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_ticks();
        test_single_frame();
        test_send_disable();
        test_store_full();
        test_output_holdoff();
        test_random_messages();
        write_send_enable(1'b1);
        finish_message(16);

        // Let the last result drain, then watch a little longer for strays.
        wait_all_results();
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && line_results_q.size() == 0) begin
            $display("** uart_multibyte_bit_transmitter: PASSED **");
        end else begin
            $display("** uart_multibyte_bit_transmitter: FAILED **");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/utx_pkg.sv
hw/rtl/utx_ctrl.sv
hw/rtl/utx_datapath.sv
hw/rtl/uart_multibyte_bit_transmitter.sv
hw/rtl/utx_checker.sv
test/tb.sv
